>>> rtl/mfbdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbdc_pkg
// Shared types and constants for the monochrome framebuffer with dirty-column
// tracking.
// ----------------------------------------------------------------------------
package mfbdc_pkg;

  localparam int DEF_WIDTH  = 128;
  localparam int DEF_HEIGHT = 64;
  localparam int PAGE_BITS  = 8;

  localparam int POS_W   = 11;
  localparam int DIRTY_W = 12;
  localparam int RANGE_W = 7;
  localparam int BYTE_W  = 8;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    COLOR_CLEAR  = 2'd0,
    COLOR_SET    = 2'd1,
    COLOR_INVERT = 2'd2
  } color_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Store access control from the sequencer.
  typedef struct packed {
    logic re;
    logic we;
  } store_ctrl_t;

  // Flush report; all zeros when nothing is reported.
  typedef struct packed {
    logic [RANGE_W-1:0] right;
    logic [RANGE_W-1:0] left;
    logic               valid;
  } range_t;

endpackage

>>> rtl/mfbdc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbdc_store
// Single-port pixel store, one byte per page, with registered read data and a
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module mfbdc_store
  import mfbdc_pkg::*;
#(
  parameter int DEPTH = DEF_WIDTH * (DEF_HEIGHT / PAGE_BITS),
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  store_ctrl_t       ctrl_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [BYTE_W-1:0] rdata_o,
  output logic              clear_done_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [AW:0]       clr_cnt_q, clr_cnt_d;
  logic [BYTE_W-1:0] rdata_q;
  logic              clearing;

  assign clearing     = (clr_cnt_q != (AW+1)'(DEPTH));
  assign clear_done_o = !clearing;
  assign clr_cnt_d    = clearing ? clr_cnt_q + (AW+1)'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem[clr_cnt_q[AW-1:0]] <= '0;
    end else if (ctrl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mfbdc_dirty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbdc_dirty
// Dirty column range: widens on draws, clamps and reports on flush, then
// empties.
// ----------------------------------------------------------------------------
module mfbdc_dirty
  import mfbdc_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             commit_i,
  input  logic             widen_i,
  input  logic             flush_i,
  input  logic [POS_W-1:0] pos_x_i,
  output range_t           range_o
);

  localparam logic signed [DIRTY_W-1:0] EMPTY_LEFT  = DIRTY_W'(WIDTH + 2);
  localparam logic signed [DIRTY_W-1:0] EMPTY_RIGHT = -DIRTY_W'(1);
  localparam logic signed [DIRTY_W-1:0] LAST_COL    = DIRTY_W'(WIDTH - 1);

  logic signed [DIRTY_W-1:0] left_q, left_d, right_q, right_d;
  logic signed [DIRTY_W-1:0] x_ext, x_m1, x_p1;
  logic signed [DIRTY_W-1:0] left_w, right_w, left_c, right_c;
  logic                      nonempty, report;

  assign x_ext = $signed({pos_x_i[POS_W-1], pos_x_i});
  assign x_m1  = x_ext - DIRTY_W'(1);
  assign x_p1  = x_ext + DIRTY_W'(1);

  assign left_w  = (widen_i && (x_m1 < left_q))  ? x_m1 : left_q;
  assign right_w = (widen_i && (x_p1 > right_q)) ? x_p1 : right_q;

  assign nonempty = (right_w > EMPTY_RIGHT) || (left_w < EMPTY_LEFT);
  assign left_c   = (left_w < 0) ? '0 : left_w;
  assign right_c  = (right_w > LAST_COL) ? LAST_COL : right_w;
  assign report   = flush_i && nonempty && (left_c <= right_c) && (left_c <= LAST_COL);

  always_comb begin
    range_o = '0;
    if (report) begin
      range_o.valid = 1'b1;
      range_o.left  = left_c[RANGE_W-1:0];
      range_o.right = right_c[RANGE_W-1:0];
    end
  end

  assign left_d  = flush_i ? EMPTY_LEFT  : left_w;
  assign right_d = flush_i ? EMPTY_RIGHT : right_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= EMPTY_LEFT;
      right_q <= EMPTY_RIGHT;
    end else if (commit_i) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

endmodule

>>> rtl/mono_framebuffer_dirty_columns_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_dirty_columns_core
// One-bit-per-pixel column-organized framebuffer with dirty-column tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel: tuser carries the kind (draw, read,
//   flush), tdata the position and draw color. Every item returns exactly one
//   word on the m_axis channel with the read pixel and the flush report.
//   The auto_flush register is written on the cfg channel, which is always
//   ready; write it only while the block is idle.
// Timing:
//   An accepted item reads its store byte in the accept cycle if on screen;
//   in the execute state a draw modifies and writes it back, and every item
//   loads the output register at the same edge. Execute waits while the
//   output register holds an untaken result. A new item is accepted only
//   after the previous one has left execute, keeping the single-port store free.
// Reset and stalls:
//   After reset the store is zeroed by a sweep over all WIDTH*HEIGHT/8 bytes
//   (1024 at the defaults); s_axis_tready stays low meanwhile. When the
//   receiver stalls, the result waits in the output register and the next
//   item waits in its execute cycle until the register frees.
// ----------------------------------------------------------------------------
module mono_framebuffer_dirty_columns_core
  import mfbdc_pkg::*;
#(
  parameter int WIDTH  = DEF_WIDTH,
  parameter int HEIGHT = DEF_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // fields from bit 0: pos_x[10:0], pos_y[21:11], color[23:22]
  input  logic [23:0] s_axis_tdata,
  // fields from bit 0: kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0: pixel[0], range_valid[1], range_left[8:2], range_right[15:9]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int ROWS  = HEIGHT / PAGE_BITS;
  localparam int DEPTH = WIDTH * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(WIDTH);

  state_e state_q, state_d;

  logic              auto_flush_q;
  logic              in_fire, exec_fire;
  logic [POS_W-1:0]  in_x, in_y;
  logic              in_on;
  logic [AW-1:0]     in_addr;

  kind_e             kind_q;
  color_e            color_q;
  logic [POS_W-1:0]  x_q, y_q;
  logic              on_q;
  logic [AW-1:0]     addr_q;

  store_ctrl_t       store_ctrl;
  logic [AW-1:0]     store_addr;
  logic [BYTE_W-1:0] rdata, wdata, mask;
  logic              wr_en, clear_done;

  logic              pixel;
  logic              widen, flush;
  range_t            range;

  logic              out_valid_q;
  logic [15:0]       out_data_q;

  // Input decode
  assign in_x    = s_axis_tdata[10:0];
  assign in_y    = s_axis_tdata[21:11];
  assign in_on   = !in_x[POS_W-1] && (in_x < POS_W'(WIDTH)) &&
                   !in_y[POS_W-1] && (in_y < POS_W'(HEIGHT));
  assign in_addr = AW'(AW'(in_x[XW-1:0]) * AW'(ROWS)) + AW'(in_y[POS_W-2:3]);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clear_done) state_d = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_EXEC;
      ST_EXEC:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    exec_fire     = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: exec_fire     = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Item register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_e'(s_axis_tuser);
      color_q <= color_e'(s_axis_tdata[23:22]);
      x_q     <= in_x;
      y_q     <= in_y;
      on_q    <= in_on;
      addr_q  <= in_addr;
    end
  end

  // Read-modify-write of one page byte
  assign mask = BYTE_W'(1) << y_q[2:0];

  always_comb begin
    wdata = rdata;
    wr_en = 1'b0;
    case (color_q)
      COLOR_CLEAR:  begin wdata = rdata & ~mask; wr_en = 1'b1; end
      COLOR_SET:    begin wdata = rdata | mask;  wr_en = 1'b1; end
      COLOR_INVERT: begin wdata = rdata ^ mask;  wr_en = 1'b1; end
      default:      ;
    endcase
  end

  assign store_ctrl.re = in_fire && in_on;
  assign store_ctrl.we = exec_fire && (kind_q == KIND_DRAW) && on_q && wr_en;
  assign store_addr    = (state_q == ST_EXEC) ? addr_q : in_addr;

  mfbdc_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (store_ctrl),
    .addr_i       (store_addr),
    .wdata_i      (wdata),
    .rdata_o      (rdata),
    .clear_done_o (clear_done)
  );

  assign widen = (kind_q == KIND_DRAW);
  assign flush = (kind_q == KIND_FLUSH) || ((kind_q == KIND_DRAW) && auto_flush_q);

  mfbdc_dirty #(
    .WIDTH (WIDTH)
  ) u_dirty (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (exec_fire),
    .widen_i  (widen),
    .flush_i  (flush),
    .pos_x_i  (x_q),
    .range_o  (range)
  );

  assign pixel = (kind_q == KIND_READ) && on_q && rdata[y_q[2:0]];

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_data_q <= {range.right, range.left, range.valid, pixel};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_flush_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      auto_flush_q <= cfg_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> clear_done)
    else $error("item accepted during store clearing");

  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC))
    else $error("accepted item did not enter execute");

  a_write_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_ctrl.we |-> (exec_fire && !store_ctrl.re))
    else $error("store write outside execute");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> m_axis_tvalid)
    else $error("executed item produced no result");
`endif

endmodule
